/* sv/bpca_pkg.sv */
// Package: shared constants and types for the button press classifier.
`default_nettype none
package bpca_pkg;

    // Repeat period divider: full period = DIV_DIVIDEND / tick period
    localparam int          DIV_W        = 8;
    localparam logic [7:0]  DIV_DIVIDEND = 8'd250;
    localparam int          DIV_CNT_W    = 4;

    // Pattern bit positions
    localparam int BIT_MODE = 0;
    localparam int BIT_UP   = 1;
    localparam int BIT_DOWN = 2;
    localparam int BIT_ENT  = 3;
    localparam int BIT_ALL  = 4;
    localparam int BIT_ANY  = 5;

    // Ramp thresholds in ticks
    localparam logic [10:0] RAMP_SLOW   = 11'd50;
    localparam logic [10:0] RAMP_MID    = 11'd450;
    localparam logic [10:0] RAMP_FAST   = 11'd850;
    localparam logic [10:0] RAMP_FASTER = 11'd1250;
    localparam logic [10:0] RAMP_MAX    = 11'd1500;

    localparam logic [4:0]  STEP_SMALL  = 5'd1;
    localparam logic [4:0]  STEP_LARGE  = 5'd15;

    typedef enum logic [2:0] {
        SPD_STOP   = 3'd0,
        SPD_SLOW   = 3'd1,
        SPD_MID    = 3'd2,
        SPD_FAST   = 3'd3,
        SPD_FASTER = 3'd4
    } speed_t;

    typedef enum logic [2:0] {
        CFG_ENABLED     = 3'd0,
        CFG_TICK_PERIOD = 3'd1,
        CFG_HOLD_TICKS  = 3'd2,
        CFG_CLICK_MIN   = 3'd3,
        CFG_VERY_LONG   = 3'd4
    } cfg_index_t;

    // Handshake between sequencer and divider
    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

/* sv/bpca_div.sv */
// Iterative restoring divider: constant dividend over a 7-bit divisor.
`default_nettype none
module bpca_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bpca_pkg::div_req_t req,
    input  wire logic [6:0]         divisor,
    output bpca_pkg::div_rsp_t      rsp
);
    import bpca_pkg::*;

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_W-1:0]     trial;
    logic                 fits;

    // Bring down one dividend bit per cycle
    assign trial = {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = DIV_DIVIDEND;
            cnt_next  = DIV_CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (trial - {1'b0, divisor}) : trial;
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

/* sv/button_press_classifier_autorepeat_unit.sv */
// Top level: button press classifier with long-press flags and auto-repeat steps.
`default_nettype none
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  in      | sink      | in_valid/in_stall  | mode/up/down/ent pins, clear, take incr.
//  out     | source    | out_valid/out_stall| held, very long, clicked, speed, incr.
//  cfg     | sink      | cfg_we             | cfg_index, cfg_data (10 bits)
//
//  Each beat is taken, then the repeat period divider works out its quotient
//  (one quotient bit per cycle) and flags done, and then the state is updated.
//  A stalled output adds its wait.
//  Reset clears all classification state, speed is stop, registers take defaults.
//  The input stalls for the whole of the work on a beat; the output register
//  holds its beat until taken and the update waits while it is still full.
//
module button_press_classifier_autorepeat_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              mode_pin,
    input  wire logic              up_pin,
    input  wire logic              down_pin,
    input  wire logic              ent_pin,
    input  wire logic              clear_clicked,
    input  wire logic              take_increment,
    // output channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [5:0]             held_flags,
    output logic [5:0]             very_long_flags,
    output logic [5:0]             clicked_flags,
    output logic [2:0]             speed_level,
    output logic signed [4:0]      increment_value,
    // configuration
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [9:0]        cfg_data
);
    import bpca_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EXEC
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic       enabled_reg;
    logic [6:0] tick_period_reg;
    logic [9:0] hold_ticks_reg;
    logic [9:0] click_min_reg;
    logic [9:0] very_long_ticks_reg;

    // Classification state
    logic [9:0]  press_count_reg, press_count_next;
    logic [5:0]  released_reg, released_next;
    logic [5:0]  held_reg, held_next;
    logic [5:0]  very_long_reg, very_long_next;
    logic [5:0]  clicked_reg, clicked_next;
    logic [5:0]  clicked_report;
    logic [9:0]  long_count_reg, long_count_next;
    logic [10:0] ramp_count_reg, ramp_count_next;
    speed_t      speed_reg, speed_next;
    logic [7:0]  phase_reg, phase_next;

    // Latched input beat
    logic [5:0]  now_reg;
    logic        clear_reg;
    logic        take_reg;

    // Output register
    logic        out_valid_reg;
    logic [5:0]  held_out_reg;
    logic [5:0]  very_long_out_reg;
    logic [5:0]  clicked_out_reg;
    logic [2:0]  speed_out_reg;
    logic [4:0]  incr_out_reg;
    logic [4:0]  incr_next;

    // Divider
    div_req_t    div_req;
    div_rsp_t    div_rsp;
    logic [6:0]  divisor;
    logic [7:0]  full_period;
    logic [7:0]  half_period;

    logic        in_take;
    logic        out_free;
    logic        do_exec;
    logic [5:0]  now_pattern;
    logic [4:0]  step_val;

    assign in_take  = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign do_exec  = (state_reg == S_EXEC) && out_free;

    // Pattern: single buttons, all four, any one
    assign now_pattern = {mode_pin | up_pin | down_pin | ent_pin,
                          mode_pin & up_pin & down_pin & ent_pin,
                          ent_pin, down_pin, up_pin, mode_pin};

    // A zero period counts as one ms
    assign divisor       = (tick_period_reg == 7'd0) ? 7'd1 : tick_period_reg;
    assign div_req.start = in_take;

    bpca_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .divisor (divisor),
        .rsp     (div_rsp)
    );

    // floor(125/t) equals floor(floor(250/t)/2)
    assign full_period = div_rsp.quotient;
    assign half_period = {1'b0, div_rsp.quotient[7:1]};

    // Classification, increment sample and click report for one beat
    always_comb
    begin
        press_count_next = press_count_reg;
        released_next    = released_reg;
        held_next        = held_reg;
        very_long_next   = very_long_reg;
        clicked_next     = clicked_reg;
        long_count_next  = long_count_reg;
        ramp_count_next  = ramp_count_reg;
        speed_next       = speed_reg;
        phase_next       = phase_reg;
        step_val         = 5'd0;
        incr_next        = 5'd0;

        if (enabled_reg)
        begin
            if (now_reg[BIT_ANY])
            begin
                released_next = now_reg;
                if (press_count_reg >= hold_ticks_reg)
                    held_next = now_reg;
                else
                    press_count_next = press_count_reg + 10'd1;
            end
            else
            begin
                // drop the click when a very long press came first
                if (very_long_reg[BIT_ANY])
                    clicked_next = 6'd0;
                else if (press_count_reg > click_min_reg)
                    clicked_next = released_reg;
                press_count_next = 10'd0;
                held_next        = 6'd0;
            end

            if (held_next[BIT_ANY])
            begin
                if (long_count_reg == very_long_ticks_reg)
                    very_long_next = now_reg;
                else
                    long_count_next = long_count_reg + 10'd1;
            end
            else
            begin
                very_long_next  = 6'd0;
                long_count_next = 10'd0;
            end

            if (held_next[BIT_UP] || held_next[BIT_DOWN])
            begin
                if (ramp_count_reg == RAMP_SLOW)
                    speed_next = SPD_SLOW;
                else if (ramp_count_reg == RAMP_MID)
                    speed_next = SPD_MID;
                else if (ramp_count_reg == RAMP_FAST)
                    speed_next = SPD_FAST;
                else if (ramp_count_reg == RAMP_FASTER)
                    speed_next = SPD_FASTER;
                if (ramp_count_reg < RAMP_MAX)
                    ramp_count_next = ramp_count_reg + 11'd1;
            end
            else
            begin
                speed_next      = SPD_STOP;
                ramp_count_next = 11'd0;
                phase_next      = 8'd0;
            end
        end

        if (take_reg)
        begin
            case (speed_next)
                SPD_SLOW:   if (phase_next == 8'd0) step_val = STEP_SMALL;
                SPD_MID:    if (phase_next == 8'd0 || phase_next == half_period)
                                step_val = STEP_SMALL;
                SPD_FAST:   if (phase_next == 8'd0) step_val = STEP_LARGE;
                SPD_FASTER: if (phase_next == 8'd0 || phase_next == half_period)
                                step_val = STEP_LARGE;
                default:    step_val = 5'd0;
            endcase
            // advance the phase, wrapping at the full period or at 8 bits
            if (phase_next == full_period)
                phase_next = 8'd0;
            else
                phase_next = phase_next + 8'd1;
            if (held_next[BIT_UP])
                incr_next = step_val;
            else if (held_next[BIT_DOWN])
                incr_next = 5'd0 - step_val;
        end

        // report the click pattern before the optional clear
        clicked_report = clicked_next;
        if (clear_reg)
            clicked_next = 6'd0;
    end

    // Sequencer, state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            enabled_reg         <= 1'b0;
            tick_period_reg     <= 7'd10;
            hold_ticks_reg      <= 10'd50;
            click_min_reg       <= 10'd5;
            very_long_ticks_reg <= 10'd150;
            press_count_reg     <= '0;
            released_reg        <= '0;
            held_reg            <= '0;
            very_long_reg       <= '0;
            clicked_reg         <= '0;
            long_count_reg      <= '0;
            ramp_count_reg      <= '0;
            speed_reg           <= SPD_STOP;
            phase_reg           <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ENABLED:     enabled_reg         <= cfg_data[0];
                    CFG_TICK_PERIOD: tick_period_reg     <= cfg_data[6:0];
                    CFG_HOLD_TICKS:  hold_ticks_reg      <= cfg_data;
                    CFG_CLICK_MIN:   click_min_reg       <= cfg_data;
                    CFG_VERY_LONG:   very_long_ticks_reg <= cfg_data;
                    default:         ;
                endcase
            end

            // drop the output beat once taken, unless a new one replaces it
            if (out_valid_reg && !out_stall && !do_exec)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        press_count_reg <= press_count_next;
                        released_reg    <= released_next;
                        held_reg        <= held_next;
                        very_long_reg   <= very_long_next;
                        clicked_reg     <= clicked_next;
                        long_count_reg  <= long_count_next;
                        ramp_count_reg  <= ramp_count_next;
                        speed_reg       <= speed_next;
                        phase_reg       <= phase_next;
                        out_valid_reg   <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg   <= now_pattern;
            clear_reg <= clear_clicked;
            take_reg  <= take_increment;
        end
        if (do_exec)
        begin
            held_out_reg      <= held_next;
            very_long_out_reg <= very_long_next;
            clicked_out_reg   <= clicked_report;
            speed_out_reg     <= speed_next;
            incr_out_reg      <= incr_next;
        end
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign held_flags      = held_out_reg;
    assign very_long_flags = very_long_out_reg;
    assign clicked_flags   = clicked_out_reg;
    assign speed_level     = speed_out_reg;
    assign increment_value = $signed(incr_out_reg);

    // A taken beat blocks the input until its update is done
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after taking a beat");

    // Speed never leaves its defined range
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (speed_level <= 3'd4))
        else $error("speed level out of range");

    // A repeat step needs a running ramp
    a_step_needs_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && increment_value != 5'sd0) |-> (speed_level != 3'd0))
        else $error("repeat step without speed");

    // A very long press is only reported while held
    a_very_long_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && very_long_flags != 6'd0) |-> held_flags[5])
        else $error("very long flags without held press");

    // The update only runs once the divider has finished
    a_exec_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !div_rsp.done) |=> (state_reg != S_EXEC))
        else $error("update entered before divider finished");

endmodule
`default_nettype wire
